// ----- rtl/core/acs_pkg.sv -----
// Shared types and constants of the accumulator CPU step core.
`default_nettype none
package acs_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned SIZE_W = 13;

  localparam logic [SIZE_W-1:0] MEM_SIZE_RST = 13'd4096;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EXEC  = 2'd2,
    REQ_RESET = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_ADDR     = 3'd1,
    FLT_OPCODE   = 3'd2,
    FLT_ARIT_REG = 3'd3,
    FLT_ARIT_OP  = 3'd4
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_DONE
  } state_e;

  // opcodes, instruction bits 15:12
  localparam logic [3:0] OP_NOP  = 4'h0;
  localparam logic [3:0] OP_LDA  = 4'h1;
  localparam logic [3:0] OP_STA  = 4'h2;
  localparam logic [3:0] OP_JMP  = 4'h3;
  localparam logic [3:0] OP_JNZ  = 4'h4;
  localparam logic [3:0] OP_ARIT = 4'h6;
  localparam logic [3:0] OP_HLT  = 4'hF;

  // ARIT operations
  localparam logic [2:0] AO_SET0 = 3'd0;
  localparam logic [2:0] AO_SETF = 3'd1;
  localparam logic [2:0] AO_NOT  = 3'd2;
  localparam logic [2:0] AO_AND  = 3'd3;
  localparam logic [2:0] AO_OR   = 3'd4;
  localparam logic [2:0] AO_XOR  = 3'd5;
  localparam logic [2:0] AO_ADD  = 3'd6;

  // register codes
  localparam logic [2:0] RC_A   = 3'd0;
  localparam logic [2:0] RC_B   = 3'd1;
  localparam logic [2:0] RC_C   = 3'd2;
  localparam logic [2:0] RC_D   = 3'd3;
  localparam logic [2:0] RC_R   = 3'd6;
  localparam logic [2:0] RC_PSW = 3'd7;

  // PSW bit positions
  localparam int unsigned PSW_OVF = 15;
  localparam int unsigned PSW_LT  = 13;
  localparam int unsigned PSW_EQ  = 12;
  localparam int unsigned PSW_GT  = 11;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] psw;
  } regs_t;

  typedef struct packed {
    regs_t             regs;
    logic [ADDR_W-1:0] pc;
    logic              halt;
    fault_e            fault;
    logic              mem_rd;
    logic              mem_wr;
    logic [ADDR_W-1:0] mem_addr;
  } exec_upd_t;

endpackage
`default_nettype wire

// ----- rtl/core/acs_in_if.sv -----
// Request channel of the accumulator CPU step core.
`default_nettype none
interface acs_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [acs_pkg::ADDR_W-1:0]  mem_addr;
  logic [acs_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, req_type, mem_addr, write_data, input ready);
  modport sink   (input valid, req_type, mem_addr, write_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/acs_out_if.sv -----
// Result channel of the accumulator CPU step core.
`default_nettype none
interface acs_out_if;
  logic                        valid;
  logic                        ready;
  logic [acs_pkg::DATA_W-1:0]  read_data;
  logic [acs_pkg::ADDR_W-1:0]  pc_now;
  logic [acs_pkg::DATA_W-1:0]  instr_word;
  logic [acs_pkg::DATA_W-1:0]  acc_value;
  logic [acs_pkg::DATA_W-1:0]  status_value;
  logic                        halted_flag;
  logic [2:0]                  fault_code;

  modport source (output valid, read_data, pc_now, instr_word, acc_value, status_value,
                  halted_flag, fault_code, input ready);
  modport sink   (input valid, read_data, pc_now, instr_word, acc_value, status_value,
                  halted_flag, fault_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/acs_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module acs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/acs_exec.sv -----
// Instruction decode and ALU: next register state for one fetched instruction.
`default_nettype none
module acs_exec (
  input  wire logic [acs_pkg::DATA_W-1:0] ir_i,
  input  wire acs_pkg::regs_t             regs_i,
  input  wire logic [acs_pkg::ADDR_W-1:0] pc_i,
  input  wire logic [acs_pkg::SIZE_W-1:0] size_i,
  output acs_pkg::exec_upd_t              upd_o
);
  import acs_pkg::*;

  function automatic logic [DATA_W-1:0] reg_rd(regs_t r, logic [2:0] code);
    logic [DATA_W-1:0] v;
    case (code)
      RC_A:    v = r.a;
      RC_B:    v = r.b;
      RC_C:    v = r.c;
      RC_D:    v = r.d;
      RC_R:    v = r.r;
      RC_PSW:  v = r.psw;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic reg_ok(logic [2:0] code);
    return (code != 3'd4) && (code != 3'd5);
  endfunction

  logic [3:0]        op;
  logic [ADDR_W-1:0] arg;
  logic [SIZE_W-1:0] pc_inc;
  logic [ADDR_W-1:0] pc_next;
  logic              arg_ok;
  logic [2:0]        opr, dst, src1, src2;
  logic [DATA_W-1:0] opa, opb, res, psw;
  logic [DATA_W:0]   sum;
  logic              wr;
  exec_upd_t         upd;

  assign op   = ir_i[15:12];
  assign arg  = ir_i[ADDR_W-1:0];
  assign opr  = arg[11:9];
  assign dst  = arg[8:6];
  assign src1 = arg[5:3];
  assign src2 = arg[2:0];

  assign pc_inc  = {1'b0, pc_i} + 13'd1;
  assign pc_next = (pc_inc >= size_i) ? '0 : pc_inc[ADDR_W-1:0];
  assign arg_ok  = {1'b0, arg} < size_i;

  // operands and ALU result
  always_comb begin
    opa = reg_rd(regs_i, src1);
    opb = src2[2] ? reg_rd(regs_i, {1'b0, src2[1:0]}) : '0;
    sum = {1'b0, opa} + {1'b0, opb};
    wr  = 1'b1;
    case (opr)
      AO_SET0: res = '0;
      AO_SETF: res = '1;
      AO_NOT:  res = ~opa;
      AO_AND:  res = opa & opb;
      AO_OR:   res = opa | opb;
      AO_XOR:  res = opa ^ opb;
      AO_ADD:  res = sum[DATA_W-1:0];
      default: begin
        res = '0;
        wr  = 1'b0;
      end
    endcase
  end

  always_comb begin
    upd          = '0;
    upd.regs     = regs_i;
    upd.pc       = pc_next;
    upd.halt     = 1'b0;
    upd.fault    = FLT_NONE;
    upd.mem_rd   = 1'b0;
    upd.mem_wr   = 1'b0;
    upd.mem_addr = arg;
    psw          = regs_i.psw;
    unique case (op)
      OP_NOP: ;
      OP_LDA: begin
        if (arg_ok) upd.mem_rd = 1'b1;
        else        upd.fault  = FLT_ADDR;
      end
      OP_STA: begin
        if (arg_ok) upd.mem_wr = 1'b1;
        else        upd.fault  = FLT_ADDR;
      end
      OP_JMP, OP_JNZ: begin
        if (!arg_ok) upd.fault = FLT_ADDR;
        if (op == OP_JMP || regs_i.a != '0) begin
          upd.regs.r = DATA_W'(pc_inc);
          upd.pc     = arg_ok ? arg : '0;
        end
      end
      OP_ARIT: begin
        if (!reg_ok(dst) || !reg_ok(src1)) begin
          upd.fault = FLT_ARIT_REG;
        end else begin
          if (!wr) upd.fault = FLT_ARIT_OP;
          if (wr) begin
            case (dst)
              RC_A:    upd.regs.a = res;
              RC_B:    upd.regs.b = res;
              RC_C:    upd.regs.c = res;
              RC_D:    upd.regs.d = res;
              RC_R:    upd.regs.r = res;
              RC_PSW:  psw        = res;
              default: ;
            endcase
          end
          // overflow and compare bits land after the destination write
          if (opr == AO_ADD) psw[PSW_OVF] = sum[DATA_W];
          psw[PSW_LT]  = opa < opb;
          psw[PSW_EQ]  = opa == opb;
          psw[PSW_GT]  = opa > opb;
          upd.regs.psw = psw;
        end
      end
      OP_HLT: begin
        upd.halt = 1'b1;
        upd.pc   = pc_i;
      end
      default: upd.fault = FLT_OPCODE;
    endcase
  end

  assign upd_o = upd;

endmodule
`default_nettype wire

// ----- rtl/core/accumulator_cpu_step_core_unit.sv -----
// Top level of the accumulator CPU step core: sequencer, registers, result stage.
//
// Usage: requests arrive on req_i (valid/ready), one result per request leaves
// on rsp_o (valid/ready). A transfer happens when valid and ready are both high.
// Request kinds: memory word write, memory word read, execute one instruction,
// reset the CPU registers. mem_size is written through cfg_we_i/cfg_wdata_i
// while no request is in flight; it is clamped to 1..MEM_WORDS internally.
// Memory requests, register reset and steps while halted go straight to the
// done state; an executed instruction passes the decode state first, and LDA
// also the load state. The single RAM port sets this: fetch in the transfer
// cycle, decode and execute (plus the STA write or LDA read) next, the LDA
// data into A in the load state. A new request is taken only while idle or in
// the cycle the previous result is loaded into the output register.
// If the receiver stalls, the finished result waits in the output register;
// the next request is still taken and worked on, and its result holds in the
// done state until the output register frees.
// Reset: registers, PC, IR and halted clear, mem_size returns to 4096. Memory
// contents are not cleared and are undefined until written.
`default_nettype none
module accumulator_cpu_step_core_unit #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [acs_pkg::SIZE_W-1:0]  cfg_wdata_i,
  acs_in_if.sink                           req_i,
  acs_out_if.source                        rsp_o
);
  import acs_pkg::*;

  localparam int unsigned       AW         = $clog2(MEM_WORDS);
  localparam logic [SIZE_W-1:0] MemWordsSz = SIZE_W'(MEM_WORDS);

  // configuration
  logic [SIZE_W-1:0] cfg_size_q;
  logic [SIZE_W-1:0] size_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= MEM_SIZE_RST;
    end else if (cfg_we_i) begin
      cfg_size_q <= cfg_wdata_i;
    end
  end

  assign size_eff = (cfg_size_q == '0)        ? 13'd1 :
                    (cfg_size_q > MemWordsSz) ? MemWordsSz : cfg_size_q;

  // architectural state
  regs_t             regs_q;
  logic [ADDR_W-1:0] pc_q;
  logic [DATA_W-1:0] ir_q;
  logic              halted_q;

  // per-item state
  state_e            state_q, state_d;
  fault_e            fault_q;
  logic              rd_sel_q;
  logic [ADDR_W-1:0] pc_f_q;

  // handshake and RAM control
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              in_ok;
  req_e              req;
  logic [ADDR_W-1:0] fetch_pc;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  exec_upd_t         upd;

  assign req      = req_e'(req_i.req_type);
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_o.valid || rsp_o.ready;
  assign in_ok    = {1'b0, req_i.mem_addr} < size_eff;
  // mem_size may have shrunk below PC: fetch from word 0 then
  assign fetch_pc = ({1'b0, pc_q} >= size_eff) ? '0 : pc_q;

  acs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr[AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  acs_exec u_exec (
    .ir_i   (ram_rdata),
    .regs_i (regs_q),
    .pc_i   (pc_f_q),
    .size_i (size_eff),
    .upd_o  (upd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (req == REQ_EXEC && !halted_q) ? ST_DECODE : ST_DONE;
      end
      ST_DECODE: state_d = upd.mem_rd ? ST_LOAD : ST_DONE;
      ST_LOAD:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          if (accept) state_d = (req == REQ_EXEC && !halted_q) ? ST_DECODE : ST_DONE;
          else        state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: request ready, RAM port, result load
  always_comb begin
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_DONE: begin
        req_i.ready = out_free;
        load_out    = out_free;
      end
      ST_DECODE: begin
        ram_we    = upd.mem_wr;
        ram_re    = upd.mem_rd;
        ram_addr  = upd.mem_addr;
        ram_wdata = regs_q.a;
      end
      default: ;
    endcase
    // request side of the port; never overlaps the decode-cycle access
    if (accept) begin
      case (req)
        REQ_WRITE: begin
          ram_we    = in_ok;
          ram_addr  = req_i.mem_addr;
          ram_wdata = req_i.write_data;
        end
        REQ_READ: begin
          ram_re   = in_ok;
          ram_addr = req_i.mem_addr;
        end
        REQ_EXEC: begin
          ram_re   = !halted_q;
          ram_addr = fetch_pc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q  <= ((req == REQ_WRITE || req == REQ_READ) && !in_ok) ? FLT_ADDR : FLT_NONE;
      rd_sel_q <= (req == REQ_READ) && in_ok;
      pc_f_q   <= fetch_pc;
    end else if (state_q == ST_DECODE) begin
      fault_q <= upd.fault;
    end
  end

  // CPU registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q   <= '0;
      pc_q     <= '0;
      ir_q     <= '0;
      halted_q <= 1'b0;
    end else if (accept && req == REQ_RESET) begin
      regs_q   <= '0;
      pc_q     <= '0;
      ir_q     <= '0;
      halted_q <= 1'b0;
    end else if (state_q == ST_DECODE) begin
      regs_q   <= upd.regs;
      pc_q     <= upd.pc;
      ir_q     <= ram_rdata;
      halted_q <= halted_q | upd.halt;
    end else if (state_q == ST_LOAD) begin
      regs_q.a <= ram_rdata;
    end
  end

  // result register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic [ADDR_W-1:0] out_pc_q;
  logic [DATA_W-1:0] out_ir_q;
  logic [DATA_W-1:0] out_acc_q;
  logic [DATA_W-1:0] out_psw_q;
  logic              out_halt_q;
  fault_e            out_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rdata_q <= rd_sel_q ? ram_rdata : '0;
      out_pc_q    <= pc_q;
      out_ir_q    <= ir_q;
      out_acc_q   <= regs_q.a;
      out_psw_q   <= regs_q.psw;
      out_halt_q  <= halted_q;
      out_fault_q <= fault_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = out_rdata_q;
  assign rsp_o.pc_now       = out_pc_q;
  assign rsp_o.instr_word   = out_ir_q;
  assign rsp_o.acc_value    = out_acc_q;
  assign rsp_o.status_value = out_psw_q;
  assign rsp_o.halted_flag  = out_halt_q;
  assign rsp_o.fault_code   = out_fault_q;

`ifndef SYNTHESIS
  // single RAM port: one access a cycle
  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  // decode owns the RAM port, so no request may transfer then
  a_decode_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE) |-> !accept)
    else $error("request transfer during decode");

  // halted clears only by a register reset request
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && !(accept && req == REQ_RESET)) |=> halted_q)
    else $error("halted cleared without reset request");

  // load data step always leads to the done state
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (state_q == ST_DONE))
    else $error("load step not followed by done");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the accumulator CPU step core: directed and random programs against a predictor.
module tb;
  import acs_pkg::*;

  localparam int unsigned WORDS     = 4096;
  localparam int unsigned CYC_LIMIT = 1_000_000;
  localparam int unsigned N_PHASES  = 10;
  localparam int unsigned PHASE_LEN = 70;
  localparam int unsigned TGT_SPAN  = 32;            // low jump, load and store targets
  localparam int unsigned FILL_LO   = 64;            // low window written up front
  localparam int unsigned HIGH_BASE = WORDS - 64;    // high window written up front

  // codes the package leaves unnamed
  localparam logic [3:0] OP_UNDEF = 4'h5;   // first of the undefined opcodes
  localparam logic [2:0] RC_NONE  = 3'd4;   // register codes 4 and 5 select nothing
  localparam logic [2:0] RC_NONE2 = 3'd5;
  localparam logic [2:0] AO_UNIMP = 3'd7;   // the unimplemented operation

  typedef struct packed {
    req_e              kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cpu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [ADDR_W-1:0] pc;
    logic [DATA_W-1:0] ir;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] psw;
    logic              halt;
    fault_e            flt;
  } cpu_rsp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  acs_in_if  req_if ();
  acs_out_if rsp_if ();

  accumulator_cpu_step_core_unit #(.MEM_WORDS(WORDS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: its own image of memory, register file and mem_size.
  // The register file is indexed by the instruction's register code, so R and
  // PSW sit at their codes; codes 4 and 5 are never written.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] mem_img [WORDS];
  logic [DATA_W-1:0] cpu_reg [8];
  logic [ADDR_W-1:0] pc_q;
  logic [DATA_W-1:0] ir_q;
  logic              halt_q;
  logic [SIZE_W-1:0] mem_lim;

  cpu_req_t    req_pend [$];   // items waiting for the driver
  cpu_rsp_t    rsp_due  [$];   // results predicted at request transfer, in order
  int unsigned src_idle;       // percent of cycles the sender holds back
  int unsigned snk_idle;       // percent of cycles the receiver stalls
  int unsigned n_err = 0;
  int unsigned n_gen = 0;
  int unsigned n_cyc = 0;

  // mem_size as the block uses it: clamped to 1..WORDS
  function automatic logic [SIZE_W-1:0] eff_words();
    if (mem_lim == '0) return SIZE_W'(1);
    if (mem_lim > SIZE_W'(WORDS)) return SIZE_W'(WORDS);
    return mem_lim;
  endfunction

  function automatic fault_e run_arit(logic [ADDR_W-1:0] arg);
    logic [2:0]        opr;
    logic [2:0]        dc;
    logic [2:0]        c1;
    logic [2:0]        c2;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W:0]   sum;
    fault_e            flt;
    opr = arg[11:9];
    dc  = arg[8:6];
    c1  = arg[5:3];
    c2  = arg[2:0];
    flt = FLT_NONE;
    // destination is checked first, but either bad code aborts with no update
    if (dc == RC_NONE || dc == RC_NONE2 || c1 == RC_NONE || c1 == RC_NONE2)
      return FLT_ARIT_REG;
    x = cpu_reg[c1];
    y = c2[2] ? cpu_reg[{1'b0, c2[1:0]}] : '0;
    case (opr)
      AO_SET0: cpu_reg[dc] = '0;
      AO_SETF: cpu_reg[dc] = '1;
      AO_NOT:  cpu_reg[dc] = ~x;
      AO_AND:  cpu_reg[dc] = x & y;
      AO_OR:   cpu_reg[dc] = x | y;
      AO_XOR:  cpu_reg[dc] = x ^ y;
      AO_ADD: begin
        sum = {1'b0, x} + {1'b0, y};
        cpu_reg[dc] = sum[DATA_W-1:0];
        cpu_reg[RC_PSW][PSW_OVF] = sum[DATA_W];
      end
      default: flt = FLT_ARIT_OP;
    endcase
    // compare bits land last, also on top of a PSW destination
    cpu_reg[RC_PSW][PSW_LT] = (x < y);
    cpu_reg[RC_PSW][PSW_EQ] = (x == y);
    cpu_reg[RC_PSW][PSW_GT] = (x > y);
    return flt;
  endfunction

  function automatic fault_e run_instr();
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W-1:0] pc;
    logic [3:0]        opc;
    logic [ADDR_W-1:0] arg;
    fault_e            flt;
    lim = eff_words();
    pc  = {1'b0, pc_q};
    flt = FLT_NONE;
    if (halt_q) return FLT_NONE;
    if (pc >= lim) pc = '0;   // size shrank under the PC: fetch from 0
    ir_q = mem_img[pc[ADDR_W-1:0]];
    opc  = ir_q[15:12];
    arg  = ir_q[11:0];
    case (opc)
      OP_NOP: ;
      OP_LDA: begin
        if ({1'b0, arg} < lim) cpu_reg[RC_A] = mem_img[arg];
        else flt = FLT_ADDR;
      end
      OP_STA: begin
        if ({1'b0, arg} < lim) mem_img[arg] = cpu_reg[RC_A];
        else flt = FLT_ADDR;
      end
      OP_JMP, OP_JNZ: begin
        if ({1'b0, arg} >= lim) flt = FLT_ADDR;
        if (opc == OP_JMP || cpu_reg[RC_A] != '0) begin
          cpu_reg[RC_R] = DATA_W'(pc + 1'b1);   // return address without wrap
          pc_q = ({1'b0, arg} >= lim) ? '0 : arg;
          return flt;
        end
      end
      OP_ARIT: flt = run_arit(arg);
      OP_HLT: begin
        halt_q = 1'b1;
        pc_q   = pc[ADDR_W-1:0];
        return FLT_NONE;
      end
      default: flt = FLT_OPCODE;
    endcase
    pc = pc + 1'b1;
    if (pc >= lim) pc = '0;
    pc_q = pc[ADDR_W-1:0];
    return flt;
  endfunction

  function automatic cpu_rsp_t cpu_step(cpu_req_t it);
    cpu_rsp_t r;
    r.rdata = '0;
    r.flt   = FLT_NONE;
    case (it.kind)
      REQ_WRITE: begin
        if ({1'b0, it.addr} < eff_words()) mem_img[it.addr] = it.data;
        else r.flt = FLT_ADDR;
      end
      REQ_READ: begin
        if ({1'b0, it.addr} < eff_words()) r.rdata = mem_img[it.addr];
        else r.flt = FLT_ADDR;
      end
      REQ_EXEC: r.flt = run_instr();
      default: begin
        for (int i = 0; i < 8; i++) cpu_reg[i] = '0;
        pc_q   = '0;
        ir_q   = '0;
        halt_q = 1'b0;
      end
    endcase
    r.pc   = pc_q;
    r.ir   = ir_q;
    r.acc  = cpu_reg[RC_A];
    r.psw  = cpu_reg[RC_PSW];
    r.halt = halt_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: the expected result is computed at the request transfer, then the
  // next item goes out unless the sender picks an idle cycle. valid only moves
  // once the slot is free, so a held item never drops.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drv
    cpu_req_t cur;
    cpu_req_t nxt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        cur.kind = req_e'(req_if.req_type);
        cur.addr = req_if.mem_addr;
        cur.data = req_if.write_data;
        rsp_due.push_back(cpu_step(cur));
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_pend.size() != 0 && $urandom_range(99) >= src_idle) begin
          nxt = req_pend.pop_front();
          req_if.valid      <= 1'b1;
          req_if.req_type   <= nxt.kind;
          req_if.mem_addr   <= nxt.addr;
          req_if.write_data <= nxt.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void chk(string fld, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
      n_err++;
    end
  endfunction

  // Monitor: every result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin : mon
    cpu_rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: result with nothing expected, pc %h ir %h", $time,
                   rsp_if.pc_now, rsp_if.instr_word);
          n_err++;
        end else begin
          want = rsp_due.pop_front();
          chk("read_data", want.rdata, rsp_if.read_data);
          chk("pc_now", DATA_W'(want.pc), DATA_W'(rsp_if.pc_now));
          chk("instr_word", want.ir, rsp_if.instr_word);
          chk("acc_value", want.acc, rsp_if.acc_value);
          chk("status_value", want.psw, rsp_if.status_value);
          chk("halted_flag", DATA_W'(want.halt), DATA_W'(rsp_if.halted_flag));
          chk("fault_code", DATA_W'(want.flt), DATA_W'(rsp_if.fault_code));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // hard stop for a hung handshake
  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc > CYC_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push(req_e k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    cpu_req_t it;
    it.kind = k;
    it.addr = a;
    it.data = d;
    req_pend.push_back(it);
    n_gen++;
  endtask

  function automatic logic [2:0] pick_reg();
    logic [2:0] codes [6];
    codes = '{RC_A, RC_B, RC_C, RC_D, RC_R, RC_PSW};
    if ($urandom_range(15) == 0) return 3'($urandom);   // now and then a bad code
    return codes[$urandom_range(5)];
  endfunction

  // Address inside one of the two prefilled windows: mostly the low one, clipped
  // to the active size; now and then the high one, out of range at small sizes.
  function automatic logic [ADDR_W-1:0] rand_arg(int unsigned hi, int unsigned span);
    if ($urandom_range(9) == 0) return ADDR_W'($urandom_range(WORDS - 1, HIGH_BASE));
    return ADDR_W'($urandom_range((hi < span - 1) ? hi : span - 1));
  endfunction

  // Mostly well-formed instructions; targets always inside the prefilled windows.
  function automatic logic [DATA_W-1:0] rand_instr(int unsigned hi);
    int unsigned       pick;
    logic [ADDR_W-1:0] arg;
    logic [2:0]        dc;
    logic [2:0]        c1;
    pick = $urandom_range(99);
    arg  = rand_arg(hi, TGT_SPAN);
    dc   = pick_reg();
    c1   = pick_reg();
    if (pick < 40) return {OP_ARIT, 3'($urandom), dc, c1, 3'($urandom)};
    if (pick < 55) return {OP_LDA, arg};
    if (pick < 67) return {OP_STA, arg};
    if (pick < 76) return {OP_JMP, arg};
    if (pick < 87) return {OP_JNZ, arg};
    if (pick < 91) return {OP_NOP, arg};
    if (pick < 93) return {OP_HLT, arg};
    return {4'($urandom), arg};
  endfunction

  // Sender holds off until every prediction has been answered. Sampled at the
  // falling edge so the driver's updates of the same cycle are settled.
  task automatic settle();
    @(negedge clk_i);
    while (req_pend.size() != 0 || req_if.valid || rsp_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] words, int unsigned s_pct, int unsigned r_pct);
    int unsigned hi;
    int unsigned goal;
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= words;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_lim  = words;
    @(negedge clk_i);
    src_idle = s_pct;
    snk_idle = r_pct;
    hi   = eff_words() - 1;
    goal = n_gen + PHASE_LEN;
    // bursts: register reset so the PC restarts at 0 in the low
    // window, a few program patches, a run of steps, some reads, and now and
    // then a random item
    while (n_gen < goal) begin
      push(REQ_RESET, ADDR_W'($urandom), DATA_W'($urandom));
      repeat ($urandom_range(5))
        push(REQ_WRITE,
             ($urandom_range(4) == 0) ? ADDR_W'($urandom)
                                      : ADDR_W'($urandom_range((hi < 15) ? hi : 15)),
             rand_instr(hi));
      repeat ($urandom_range(24, 4)) push(REQ_EXEC, ADDR_W'($urandom), DATA_W'($urandom));
      repeat ($urandom_range(2))
        push(REQ_READ, rand_arg(hi, FILL_LO), DATA_W'($urandom));
      if ($urandom_range(9) == 0)
        push(req_e'($urandom_range(3)), rand_arg(hi, FILL_LO), rand_instr(hi));
    end
  endtask

  initial begin : stim
    logic [SIZE_W-1:0] sizes [N_PHASES];
    int unsigned       s_pat [4];
    int unsigned       r_pat [4];
    sizes = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd37, 13'd4097, 13'd256, 13'd2,
              13'd4095, 13'd700};
    // no idling, sender idle, receiver stalling, both a little
    s_pat = '{0, 72, 0, 6};
    r_pat = '{0, 0, 72, 6};

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_WRITE;
    req_if.mem_addr   = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    src_idle          = 0;
    snk_idle          = 0;
    mem_lim           = MEM_SIZE_RST;
    for (int i = 0; i < 8; i++) cpu_reg[i] = '0;
    pc_q   = '0;
    ir_q   = '0;
    halt_q = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the low and high windows first. Targets stay inside them and every
    // step run starts at 0, so fetches, loads and reads never touch a word that
    // was never written; a jump into the high window wraps back into the low.
    for (int i = 0; i < FILL_LO; i++) push(REQ_WRITE, ADDR_W'(i), rand_instr(WORDS - 1));
    for (int i = HIGH_BASE; i < WORDS; i++) push(REQ_WRITE, ADDR_W'(i), rand_instr(WORDS - 1));
    settle();

    // Directed program at the reset size: extreme address and data, load,
    // add with carry, the unimplemented op, a bad register, a bad opcode,
    // store, taken JNZ, add into PSW, jump onto a HLT, a step while halted.
    push(REQ_WRITE, 12'hFFF, 16'hFFFF);
    push(REQ_READ,  12'hFFF, 16'h0000);
    push(REQ_WRITE, 12'h000, {OP_LDA, 12'hFFF});
    push(REQ_WRITE, 12'h001, {OP_ARIT, AO_ADD, RC_B, RC_A, 1'b1, RC_A[1:0]});
    push(REQ_WRITE, 12'h002, {OP_ARIT, AO_UNIMP, RC_A, RC_A, 1'b1, RC_B[1:0]});
    push(REQ_WRITE, 12'h003, {OP_ARIT, AO_OR, RC_NONE, RC_A, 1'b1, RC_B[1:0]});
    push(REQ_WRITE, 12'h004, {OP_UNDEF, 12'h123});
    push(REQ_WRITE, 12'h005, {OP_STA, 12'h010});
    push(REQ_WRITE, 12'h006, {OP_JNZ, 12'h008});
    push(REQ_WRITE, 12'h008, {OP_ARIT, AO_ADD, RC_PSW, RC_A, 1'b1, RC_B[1:0]});
    push(REQ_WRITE, 12'h009, {OP_JMP, 12'hFFF});
    push(REQ_RESET, 12'h000, 16'h0000);
    repeat (11) push(REQ_EXEC, 12'h000, 16'h0000);
    push(REQ_READ,  12'h010, 16'h0000);
    push(REQ_RESET, 12'hFFF, 16'hFFFF);

    for (int p = 0; p < N_PHASES; p++) run_phase(sizes[p], s_pat[p % 4], r_pat[p % 4]);

    settle();
    repeat (12) @(posedge clk_i);
    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/acs_pkg.sv
rtl/core/acs_in_if.sv
rtl/core/acs_out_if.sv
rtl/core/acs_ram.sv
rtl/core/acs_exec.sv
rtl/core/accumulator_cpu_step_core_unit.sv
tb/tb.sv
